// ===== rtl/signed_interleaved_exp_golomb_decoder_unit_assert.svh =====
// Assertion macros used by the checker file.
// Every property is clocked on clk and disabled while rst_n is low.
`ifndef SIGNED_INTERLEAVED_EXP_GOLOMB_DECODER_UNIT_ASSERT_SVH
`define SIGNED_INTERLEAVED_EXP_GOLOMB_DECODER_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define SIEG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Antecedent implies consequent in the next cycle.
`define SIEG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/sieg_pkg.sv =====
// ----------------------------------------------------------------------------
// sieg_pkg
// Types and constants of the signed interleaved exp-Golomb decoder.
// ----------------------------------------------------------------------------
package sieg_pkg;

  localparam int unsigned COUNT_W         = 16;
  localparam int unsigned COEF_W          = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [COUNT_W-1:0] COUNT_RESET = 16'd1024;
  localparam logic [COEF_W-1:0]  ACC_LIMIT   = 32'h8000_0000;

  typedef enum logic [1:0] {
    CMD_DATA    = 2'd0,
    CMD_PAD     = 2'd1,
    CMD_RESTART = 2'd2,
    CMD_UNUSED  = 2'd3
  } sieg_cmd_t;

  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_FOLLOW = 2'd1,
    PH_DATA   = 2'd2,
    PH_SIGN   = 2'd3
  } sieg_phase_t;

  typedef struct packed {
    sieg_cmd_t  cmd;
    logic [7:0] coded_byte;
  } sieg_in_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coefficient;
    logic                     last_of_item;
    logic                     block_done;
  } sieg_out_t;

  // Queue entry: a restart marker or eight code bits.
  typedef struct packed {
    logic       restart;
    logic [7:0] bits;
  } sieg_entry_t;

endpackage

// ===== rtl/sieg_front.sv =====
// ----------------------------------------------------------------------------
// sieg_front
// Input stage: accepts commands, drops unused codes, expands pad bytes.
// ----------------------------------------------------------------------------
module sieg_front (
  input  logic                 in_valid,
  output logic                 in_stall,
  input  sieg_pkg::sieg_in_t   in_data,
  input  logic                 q_full,
  output logic                 push,
  output sieg_pkg::sieg_entry_t push_data
);
  import sieg_pkg::*;

  logic accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    push              = 1'b0;
    push_data.restart = 1'b0;
    push_data.bits    = in_data.coded_byte;
    unique case (in_data.cmd)
      CMD_DATA: begin
        push = accept;
      end
      CMD_PAD: begin
        push           = accept;
        push_data.bits = 8'hFF;
      end
      CMD_RESTART: begin
        push              = accept;
        push_data.restart = 1'b1;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/sieg_queue.sv =====
// ----------------------------------------------------------------------------
// sieg_queue
// Small FIFO between the input stage and the bit decoder.
// ----------------------------------------------------------------------------
module sieg_queue #(
  parameter int unsigned DEPTH = sieg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  sieg_pkg::sieg_entry_t push_data,
  output logic                  full,
  input  logic                  pop,
  output sieg_pkg::sieg_entry_t head,
  output logic                  head_valid
);
  import sieg_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  sieg_entry_t   mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == FULL_CNT);
  assign head_valid = (cnt_r != '0);
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/sieg_back.sv =====
// ----------------------------------------------------------------------------
// sieg_back
// Bit decoder: one code bit per cycle through the four-phase machine, with a
// registered result stage; an empty queue or a held result pauses it.
// ----------------------------------------------------------------------------
module sieg_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [sieg_pkg::COUNT_W-1:0] cfg_count,
  input  sieg_pkg::sieg_entry_t       head,
  input  logic                        head_valid,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output sieg_pkg::sieg_out_t         out_data
);
  import sieg_pkg::*;

  // True if the bits below position idx emit a result, starting from the
  // start phase (the phase after any emission).
  function automatic logic more_emits(logic [7:0] bits, logic [2:0] idx);
    sieg_phase_t ph;
    logic        found;
    ph    = PH_START;
    found = 1'b0;
    for (int j = 6; j >= 0; j--) begin
      if (j < int'(idx) && !found) begin
        unique case (ph)
          PH_START: begin
            if (bits[j]) found = 1'b1;
            else         ph    = PH_DATA;
          end
          PH_FOLLOW: ph = bits[j] ? PH_SIGN : PH_DATA;
          PH_DATA:   ph = PH_FOLLOW;
          PH_SIGN:   found = 1'b1;
        endcase
      end
    end
    return found;
  endfunction

  sieg_phase_t         phase_r, phase_nxt;
  logic [COEF_W-1:0]   acc_r, acc_nxt;
  logic [COUNT_W-1:0]  count_r, count_nxt;
  logic                busy_r, busy_nxt;
  logic [7:0]          byte_r, byte_nxt;
  logic [2:0]          idx_r, idx_nxt;
  logic                out_valid_r, out_valid_nxt;
  sieg_out_t           out_data_r, out_data_nxt;

  logic [7:0]          src_byte;
  logic [2:0]          src_idx;
  logic                have_bit;
  logic                bit_val;
  logic                active;
  logic                emit;
  logic                out_free;
  logic                step;
  logic                restart_go;
  logic [COEF_W:0]     grown;
  logic [COEF_W-1:0]   acc_sat;
  logic [COEF_W-1:0]   mag;
  logic [COEF_W-1:0]   coef;
  logic [COUNT_W-1:0]  count_inc;
  logic                is_last;

  // Bit source: the held byte, or the queue head for its first bit.
  assign src_byte = busy_r ? byte_r : head.bits;
  assign src_idx  = busy_r ? idx_r : 3'd7;
  assign have_bit = busy_r || (head_valid && !head.restart);
  assign bit_val  = src_byte[src_idx];

  assign active   = (count_r < cfg_count);
  assign emit     = active && ((phase_r == PH_START && bit_val) || phase_r == PH_SIGN);
  assign out_free = !out_valid_r || !out_stall;
  assign step     = have_bit && (!emit || out_free);

  assign restart_go = !busy_r && head_valid && head.restart;
  assign pop        = restart_go || (!busy_r && head_valid && !head.restart && step);

  assign grown     = {acc_r, 1'b0} + {{COEF_W{1'b0}}, bit_val};
  assign acc_sat   = (grown > {1'b0, ACC_LIMIT}) ? ACC_LIMIT : grown[COEF_W-1:0];
  assign mag       = (acc_r == '0) ? '0 : acc_r - COEF_W'(1);
  assign coef      = (phase_r == PH_SIGN) ? (bit_val ? ('0 - mag) : mag) : '0;
  assign count_inc = count_r + COUNT_W'(1);
  assign is_last   = (src_idx == 3'd0) || (count_inc >= cfg_count) ||
                     !more_emits(src_byte, src_idx);

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    count_nxt = count_r;
    busy_nxt  = busy_r;
    byte_nxt  = byte_r;
    idx_nxt   = idx_r;
    if (restart_go) begin
      phase_nxt = PH_START;
      acc_nxt   = '0;
      count_nxt = '0;
    end else if (step) begin
      byte_nxt = src_byte;
      idx_nxt  = src_idx - 3'd1;
      busy_nxt = (src_idx != 3'd0);
      if (active) begin
        unique case (phase_r)
          PH_START: begin
            if (bit_val) begin
              acc_nxt = '0;
            end else begin
              acc_nxt   = COEF_W'(1);
              phase_nxt = PH_DATA;
            end
          end
          PH_FOLLOW: phase_nxt = bit_val ? PH_SIGN : PH_DATA;
          PH_DATA: begin
            acc_nxt   = acc_sat;
            phase_nxt = PH_FOLLOW;
          end
          PH_SIGN: begin
            acc_nxt   = '0;
            phase_nxt = PH_START;
          end
        endcase
      end
      if (emit) begin
        count_nxt = count_inc;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (step && emit) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.coefficient  = coef;
      out_data_nxt.last_of_item = is_last;
      out_data_nxt.block_done   = (count_inc == cfg_count);
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_START;
      acc_r       <= '0;
      count_r     <= '0;
      busy_r      <= 1'b0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      acc_r       <= acc_nxt;
      count_r     <= count_nxt;
      busy_r      <= busy_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/signed_interleaved_exp_golomb_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// signed_interleaved_exp_golomb_decoder_unit
// Signed interleaved exp-Golomb coefficient decoder, top level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data): one command per transaction,
//   a coded byte (bits used MSB first), a pad byte of eight 1 bits, or a
//   restart that clears phase, accumulator and coefficient count. The unused
//   command code is accepted and dropped.
//   Result channel (out_valid / out_stall / out_data): one decoded coefficient
//   per transaction, with last_of_item on the final result of a command and
//   block_done when the count reaches cfg_count.
//   Config (cfg_we / cfg_wdata): coefficient count per block, write while idle.
// Timing:
//   The decoder resolves one code bit per cycle unless a held result stops it
//   or no bit is available. With the decoder idle, a result from the first bit
//   of a byte is registered in the queue and then in the result register
//   before it reaches out_valid.
//   A QUEUE_DEPTH-entry queue lets new commands in while the decoder works.
//   When out_stall holds a result, the decoder stops at the next bit that
//   would emit; the queue fills and then in_stall rises.
// Reset (rst_n, synchronous): phase start, count zero, coefficient count 1024,
//   queue empty, no result pending.
// ----------------------------------------------------------------------------
module signed_interleaved_exp_golomb_decoder_unit #(
  parameter int unsigned QUEUE_DEPTH = sieg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  sieg_pkg::sieg_in_t           in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output sieg_pkg::sieg_out_t          out_data,
  input  logic                         cfg_we,
  input  logic [sieg_pkg::COUNT_W-1:0] cfg_wdata
);
  import sieg_pkg::*;

  // Coefficient count register
  logic [COUNT_W-1:0] cfg_count_r, cfg_count_nxt;

  // Front-to-queue and queue-to-decoder links
  logic        q_push;
  sieg_entry_t q_push_data;
  logic        q_full;
  logic        q_pop;
  sieg_entry_t q_head;
  logic        q_head_valid;

  assign cfg_count_nxt = cfg_we ? cfg_wdata : cfg_count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= COUNT_RESET;
    end else begin
      cfg_count_r <= cfg_count_nxt;
    end
  end

  // Front: take commands, drop unused codes, expand pads
  sieg_front u_front (
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (q_push),
    .push_data (q_push_data)
  );

  // Decoupling queue
  sieg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_head_valid)
  );

  // Back: bit-serial phase machine and result register
  sieg_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_count  (cfg_count_r),
    .head       (q_head),
    .head_valid (q_head_valid),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule

// ===== rtl/sieg_checker.sv =====
// ----------------------------------------------------------------------------
// sieg_checker
// Port-level checks of the decoder's result channel.
// ----------------------------------------------------------------------------
`include "signed_interleaved_exp_golomb_decoder_unit_assert.svh"

module sieg_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                out_valid,
  input logic                out_stall,
  input sieg_pkg::sieg_out_t out_data
);
  import sieg_pkg::*;

  // A held result stays and does not change.
  `SIEG_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")

  // Nothing follows block completion within the same command.
  `SIEG_ASSERT_SAME(a_done_last, out_valid && out_data.block_done, out_data.last_of_item, "block_done without last_of_item")

  // Saturation keeps magnitudes at or below 2^31-1.
  `SIEG_ASSERT_SAME(a_no_min, out_valid, out_data.coefficient != 32'sh8000_0000, "coefficient reached -2^31")

endmodule

bind signed_interleaved_exp_golomb_decoder_unit sieg_checker u_sieg_checker (.*);

// ===== sim/sieg_coef_tracker_pkg.sv =====
// ----------------------------------------------------------------------------
// sieg_coef_tracker_pkg
// Coefficient tracker for the exp-Golomb decoder testbench.
// Decodes each accepted command on its own copy of the decoder state, queues
// the coefficients it should yield and compares the ones the block returns.
// ----------------------------------------------------------------------------
package sieg_coef_tracker_pkg;
  import sieg_pkg::*;

  class coef_tracker;
    logic [COUNT_W-1:0] block_length = COUNT_RESET;
    logic [COUNT_W-1:0] produced     = '0;
    logic [COEF_W-1:0]  acc          = '0;
    sieg_phase_t        phase        = PH_START;
    sieg_out_t          expected_coefs[$];
    int                 failures     = 0;

    // Decode one accepted command, bits MSB first.
    function void note_item(sieg_in_t item);
      logic [7:0]        bits_v;
      logic [COEF_W:0]   grown;
      logic [COEF_W-1:0] mag;
      sieg_out_t         found[8];
      int                n;
      bit                emit;
      n = 0;
      case (item.cmd)
        CMD_RESTART: begin
          phase    = PH_START;
          acc      = '0;
          produced = '0;
          return;
        end
        CMD_UNUSED: return;
        CMD_PAD: bits_v = 8'hFF;
        default: bits_v = item.coded_byte;
      endcase
      for (int i = 7; i >= 0; i--) begin
        emit = 1'b0;
        mag  = '0;
        // once the block is complete, bits fall through untouched
        if (produced < block_length) begin
          case (phase)
            PH_START: begin
              if (bits_v[i]) begin
                acc  = '0;
                emit = 1'b1;
              end else begin
                acc   = 1;
                phase = PH_DATA;
              end
            end
            PH_FOLLOW: phase = bits_v[i] ? PH_SIGN : PH_DATA;
            PH_DATA: begin
              grown = {acc, bits_v[i]};
              acc   = (grown > {1'b0, ACC_LIMIT}) ? ACC_LIMIT : grown[COEF_W-1:0];
              phase = PH_FOLLOW;
            end
            default: begin
              mag = (acc == '0) ? '0 : acc - 1'b1;
              if (bits_v[i]) mag = -mag;
              acc   = '0;
              phase = PH_START;
              emit  = 1'b1;
            end
          endcase
        end
        if (emit) begin
          produced                = produced + 1'b1;
          found[n].coefficient    = mag;
          found[n].last_of_item   = 1'b0;
          found[n].block_done     = (produced == block_length);
          n++;
        end
      end
      if (n > 0) found[n-1].last_of_item = 1'b1;
      for (int k = 0; k < n; k++) expected_coefs.push_back(found[k]);
    endfunction

    function void check_coef(sieg_out_t got);
      sieg_out_t want;
      if (expected_coefs.size() == 0) begin
        $error("coefficient %0d arrived with none expected", got.coefficient);
        failures++;
        return;
      end
      want = expected_coefs.pop_front();
      if (got.coefficient !== want.coefficient) begin
        $error("coefficient: expected %0d, actual %0d", want.coefficient, got.coefficient);
        failures++;
      end
      if (got.last_of_item !== want.last_of_item) begin
        $error("last_of_item: expected %0b, actual %0b", want.last_of_item, got.last_of_item);
        failures++;
      end
      if (got.block_done !== want.block_done) begin
        $error("block_done: expected %0b, actual %0b", want.block_done, got.block_done);
        failures++;
      end
    endfunction
  endclass

endpackage

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for signed_interleaved_exp_golomb_decoder_unit.
// Directed commands cover all-ones bytes, pads, restarts, the unused code and
// accumulator saturation in both signs; random phases then sweep the block
// length through its extremes, including a length lowered below the running
// count, with bursty input, patterned output stalls and one long hold-off.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sieg_pkg::*;
  import sieg_coef_tracker_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 12;
  // worst case: two queued bytes plus the one in the bit decoder
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD    = 300;
  localparam int IDLE_LIMIT   = 3000;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  sieg_in_t            in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sieg_out_t           out_data;
  logic                cfg_we    = 1'b0;
  logic [COUNT_W-1:0]  cfg_wdata = '0;

  coef_tracker tracker = new;

  // sender burst shaping
  int burst_left = 0;
  int max_gap    = 4;
  // set by the main sequence, consumed by the receiver
  bit hold_pending = 1'b0;

  signed_interleaved_exp_golomb_decoder_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #(CLK_HALF) clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Result side: check every accepted coefficient transaction. Values read
  // right after the edge are the ones the edge itself sampled.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) tracker.check_coef(out_data);
  end

  // Receiver stall pattern: the mode switches at random among
  // never stalling, light and heavy random stalls and a periodic pattern.
  // A hold request freezes the output long enough to back up the input queue.
  initial begin : receiver
    int mode   = 0;
    int left   = 0;
    int hold   = 0;
    int tick   = 0;
    int period = 3;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        hold         = LONG_HOLD;
      end
      if (left == 0) begin
        mode   = $urandom_range(0, 3);
        left   = $urandom_range(40, 160);
        period = $urandom_range(2, 6);
      end
      left--;
      tick++;
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 99) < 25);
          2: out_stall <= ($urandom_range(0, 99) < 70);
          default: out_stall <= ((tick % period) == 0);
        endcase
      end
    end
  end

  // Watchdog: ends the run if no transaction moves on either channel for
  // too long. The long hold-off and drain pauses fit well inside the limit.
  initial begin : watchdog
    int idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic sieg_in_t item_of(sieg_cmd_t cmd, logic [7:0] coded);
    sieg_in_t item;
    item.cmd        = cmd;
    item.coded_byte = coded;
    return item;
  endfunction

  // Mostly data bytes; a quarter of them sparse in ones so that long codes
  // (and large magnitudes) turn up. Ignored fields still carry random bits.
  function automatic sieg_in_t random_item(int restart_pct);
    int         roll;
    logic [7:0] coded;
    roll  = $urandom_range(0, 99);
    coded = ($urandom_range(0, 3) == 0) ? 8'($urandom & $urandom & $urandom) : 8'($urandom);
    if (roll < restart_pct)           return item_of(CMD_RESTART, coded);
    else if (roll < restart_pct + 4)  return item_of(CMD_UNUSED, coded);
    else if (roll < restart_pct + 14) return item_of(CMD_PAD, coded);
    else                              return item_of(CMD_DATA, coded);
  endfunction

  // Called at a rising edge; returns at the edge that accepted the transaction, or after the gap that follows it.
  task automatic send_item(sieg_in_t item);
    int gap;
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    tracker.note_item(item);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 8);
    end
  endtask

  task automatic run_random(int items, int restart_pct);
    repeat (items) send_item(random_item(restart_pct));
  endtask

  // Wait for all expected coefficients, then let the bit decoder run out
  // any bytes that yield nothing.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.expected_coefs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_block_length(logic [COUNT_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker.block_length = value;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, block length at its reset value.
    send_item(item_of(CMD_DATA, 8'hFF));     // eight zero coefficients
    send_item(item_of(CMD_PAD, 8'h00));
    send_item(item_of(CMD_UNUSED, 8'h5A));   // dropped, no state change
    send_item(item_of(CMD_RESTART, 8'hA5));
    send_item(item_of(CMD_DATA, 8'h20));     // +1 then a partial code
    send_item(item_of(CMD_RESTART, 8'h00));
    // 72 zero bits push the accumulator into saturation; pad closes it negative
    repeat (9) send_item(item_of(CMD_DATA, 8'h00));
    send_item(item_of(CMD_PAD, 8'hFF));
    // same again, closed with a positive sign
    repeat (9) send_item(item_of(CMD_DATA, 8'h00));
    send_item(item_of(CMD_DATA, 8'hBF));

    max_gap = 10;

    // one coefficient per block: block_done on nearly every result
    write_block_length(16'd1);
    run_random(40, 30);

    // zero length: nothing is ever produced
    write_block_length(16'd0);
    run_random(15, 10);

    // maximum length, with a long output hold-off to fill the input queue
    write_block_length(16'hFFFF);
    hold_pending = 1'b1;
    run_random(110, 2);

    // lowered below the running count: idle until the next restart
    write_block_length(16'd3);
    run_random(70, 20);

    write_block_length(COUNT_W'($urandom_range(2, 40)));
    run_random(110, 5);

    wait_drained();
    if (tracker.expected_coefs.size() != 0) begin
      $error("%0d expected coefficients never arrived", tracker.expected_coefs.size());
      tracker.failures++;
    end
    if (tracker.failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== signed_interleaved_exp_golomb_decoder_unit.f =====
+incdir+rtl
rtl/sieg_pkg.sv
rtl/sieg_front.sv
rtl/sieg_queue.sv
rtl/sieg_back.sv
rtl/signed_interleaved_exp_golomb_decoder_unit.sv
rtl/sieg_checker.sv
sim/sieg_coef_tracker_pkg.sv
sim/testbench.sv
